// ===== rtl/b2a_pkg.sv =====
// ----------------------------------------------------------------------------
// b2a_pkg
// Shared types, constants and helpers for the binary-to-ASCII formatter.
// ----------------------------------------------------------------------------
package b2a_pkg;

  localparam int VALUE_W    = 32;
  localparam int DIG_W      = 4;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = BCD_DIGITS * DIG_W;
  localparam int HEX_DIGITS = 8;
  localparam int CNT_W      = 4;   // holds a digit count up to BCD_DIGITS
  localparam int STEP_W     = 5;   // indexes the VALUE_W conversion steps

  localparam logic [1:0] OP_UDEC = 2'd0;
  localparam logic [1:0] OP_SDEC = 2'd1;
  localparam logic [1:0] OP_HEX  = 2'd2;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_ALPHA = 8'h37;  // 'A' - 10
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  typedef struct packed {
    logic [1:0]         op;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } out_item_t;

  // Digit run handed to the character emitter
  typedef struct packed {
    logic [BCD_W-1:0] digits;  // most significant digit in the top nibble
    logic [CNT_W-1:0] ndig;    // digits in the run, 1..BCD_DIGITS
    logic             neg;     // emit a minus sign first
    logic             skip;    // drop leading zero digits, keep at least one
  } run_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } fmt_state_t;

  // Map one digit (0..15) to its upper-case ASCII code
  function automatic logic [7:0] digit_to_ascii(input logic [DIG_W-1:0] d);
    logic [7:0] ext;
    ext = {{(8-DIG_W){1'b0}}, d};
    return (d > 4'd9) ? (ext + ASCII_ALPHA) : (ext + ASCII_ZERO);
  endfunction

endpackage

// ===== rtl/b2a_dabble.sv =====
// ----------------------------------------------------------------------------
// b2a_dabble
// Bit-serial binary to BCD converter: shift-and-add-3, one bit per cycle.
// ----------------------------------------------------------------------------
module b2a_dabble import b2a_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VALUE_W-1:0] value,
  output logic               done,
  output logic [BCD_W-1:0]   bcd
);

  logic [VALUE_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [BCD_W-1:0]   adj;

  // Correct every BCD digit that would overflow on the next doubling
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_r[i*DIG_W +: DIG_W] >= 4'd5) begin
        adj[i*DIG_W +: DIG_W] = bcd_r[i*DIG_W +: DIG_W] + 4'd3;
      end else begin
        adj[i*DIG_W +: DIG_W] = bcd_r[i*DIG_W +: DIG_W];
      end
    end
  end

  // Load on start, then shift one binary bit into the BCD register per cycle
  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = value;
      bcd_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      {bcd_nxt, bin_nxt} = {adj[BCD_W-2:0], bin_r, 1'b0};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(VALUE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    step_r <= step_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

// ===== rtl/b2a_emit.sv =====
// ----------------------------------------------------------------------------
// b2a_emit
// Character emitter: shifts a digit run out as ASCII, one nibble per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module b2a_emit import b2a_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  run_t      run,
  output logic      busy,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [BCD_W-1:0] dig_r, dig_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;
  logic             skip_r, skip_nxt;
  logic             busy_r, busy_nxt;
  logic             oval_r, oval_nxt;
  out_item_t        odat_r, odat_nxt;
  logic             can_put;
  logic [DIG_W-1:0] top_dig;

  assign can_put = !oval_r || !out_stall;
  assign top_dig = dig_r[BCD_W-1 -: DIG_W];

  // Drop leading zeros, then sign, then digits into the output register
  always_comb begin
    dig_nxt  = dig_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    skip_nxt = skip_r;
    busy_nxt = busy_r;
    odat_nxt = odat_r;
    oval_nxt = oval_r && out_stall;
    if (load) begin
      dig_nxt  = run.digits;
      cnt_nxt  = run.ndig;
      neg_nxt  = run.neg;
      skip_nxt = run.skip;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      priority if (skip_r) begin
        if (top_dig == '0 && cnt_r > CNT_W'(1)) begin
          dig_nxt = {dig_r[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          skip_nxt = 1'b0;
        end
      end else if (can_put && neg_r) begin
        neg_nxt            = 1'b0;
        oval_nxt           = 1'b1;
        odat_nxt.char_code = ASCII_MINUS;
        odat_nxt.last      = 1'b0;
      end else if (can_put) begin
        oval_nxt           = 1'b1;
        odat_nxt.char_code = digit_to_ascii(top_dig);
        odat_nxt.last      = (cnt_r == CNT_W'(1));
        dig_nxt            = {dig_r[BCD_W-DIG_W-1:0], {DIG_W{1'b0}}};
        cnt_nxt            = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      oval_r <= oval_nxt;
    end
    dig_r  <= dig_nxt;
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    skip_r <= skip_nxt;
    odat_r <= odat_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = oval_r;
  assign out_data  = odat_r;

endmodule

// ===== rtl/binary_to_ascii_number_formatter_unit.sv =====
// Timing: decimal numbers first pass through the 32-step bit-serial BCD
//   conversion and drop leading zeros; hex numbers skip both steps.
// Flow: a new number is accepted only after the last character of the previous
//   one has entered the output register; output stalls hold the character port.
// Reset: synchronous active-low rst_n clears all control state; no stored data.
// ----------------------------------------------------------------------------
// binary_to_ascii_number_formatter_unit
// Formats a 32-bit value as unsigned decimal, signed decimal or 8-digit hex,
// one ASCII character per output transaction, last character marked.
// ----------------------------------------------------------------------------
module binary_to_ascii_number_formatter_unit import b2a_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  fmt_state_t         state_r, state_nxt;
  logic               neg_r, neg_nxt;
  logic               in_acc;
  logic               is_hex;
  logic               is_neg;
  logic [VALUE_W-1:0] mag;
  logic               dab_start;
  logic               dab_done;
  logic [BCD_W-1:0]   dab_bcd;
  logic               emit_load;
  logic               emit_busy;
  run_t               run;

  assign in_acc = in_valid && !in_stall;
  assign is_hex = in_data.op[1];
  assign is_neg = (in_data.op == OP_SDEC) && in_data.value[VALUE_W-1];
  assign mag    = is_neg ? (~in_data.value + 1'b1) : in_data.value;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = is_hex ? ST_EMIT : ST_CONV;
        end
      end
      ST_CONV: begin
        if (dab_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emit_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: start conversion or hand a digit run to the emitter
  always_comb begin
    in_stall  = 1'b1;
    dab_start = 1'b0;
    emit_load = 1'b0;
    neg_nxt   = neg_r;
    run       = '{digits: dab_bcd, ndig: CNT_W'(BCD_DIGITS), neg: neg_r, skip: 1'b1};
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_acc) begin
          neg_nxt = is_neg;
          if (is_hex) begin
            emit_load = 1'b1;
            run = '{digits: {in_data.value, {(BCD_W-VALUE_W){1'b0}}},
                    ndig: CNT_W'(HEX_DIGITS), neg: 1'b0, skip: 1'b0};
          end else begin
            dab_start = 1'b1;
          end
        end
      end
      ST_CONV: begin
        emit_load = dab_done;
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    neg_r <= neg_nxt;
  end

  b2a_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dab_start),
    .value (mag),
    .done  (dab_done),
    .bcd   (dab_bcd)
  );

  b2a_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (emit_load),
    .run       (run),
    .busy      (emit_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/tb_binary_to_ascii_number_formatter_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_to_ascii_number_formatter_unit
// Self-checking bench for the number formatter. Sends (op, value) numbers
// through the input channel. A predictor builds the expected character
// string for each accepted number. A checker compares every output character
// and its last flag in order. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module tb_binary_to_ascii_number_formatter_unit;
  import b2a_pkg::*;

  // op 3 decodes on its high bit only and acts as hex
  localparam logic [1:0] OP_HEX_ALIAS = 2'd3;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         DRAIN_CYCLES = 60;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  out_item_t pending_chars[$];
  out_item_t want_char;
  int        errors       = 0;
  int        tx_idle_pct  = 19;
  int        rx_idle_pct  = 19;
  int        quiet_cycles = 0;

  binary_to_ascii_number_formatter_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Build the character string one number should produce
  function automatic void predict_chars(input in_item_t item);
    logic [7:0]  digs[$];
    logic [31:0] mag;
    logic [3:0]  nib;
    logic        neg;
    out_item_t   ch;
    int          k;
    if (item.op[1]) begin
      for (k = HEX_DIGITS - 1; k >= 0; k--) begin
        nib = item.value[4*k +: 4];
        ch.char_code = (nib > 4'd9) ? ASCII_ALPHA + 8'(nib) : ASCII_ZERO + 8'(nib);
        ch.last = (k == 0);
        pending_chars.push_back(ch);
      end
    end else begin
      neg = (item.op == OP_SDEC) && item.value[31];
      mag = neg ? (~item.value + 32'd1) : item.value;
      do begin
        digs.push_front(ASCII_ZERO + 8'(mag % 32'd10));
        mag = mag / 32'd10;
      end while (mag != 32'd0);
      if (neg) begin
        digs.push_front(ASCII_MINUS);
      end
      foreach (digs[i]) begin
        ch.char_code = digs[i];
        ch.last = (i == digs.size() - 1);
        pending_chars.push_back(ch);
      end
    end
  endfunction

  // Favor values near decimal and sign boundaries, keep some fully random
  function automatic logic [31:0] pick_value();
    logic [31:0] p10;
    int          k;
    p10 = 32'd1;
    case ($urandom_range(5))
      0: return 32'($urandom_range(99));
      1: begin
        k = $urandom_range(9);
        repeat (k) p10 = p10 * 32'd10;
        return p10 + 32'($urandom_range(2)) - 32'd1;
      end
      2: return $urandom_range(1) ? 32'h8000_0000 + 32'($urandom_range(15))
                                  : 32'h7FFF_FFFF - 32'($urandom_range(15));
      3: return 32'hFFFF_FFFF - 32'($urandom_range(15));
      default: return $urandom;
    endcase
  endfunction

  // Send one number; return at the edge that accepts it
  task automatic send_number(input logic [1:0] op, input logic [31:0] value);
    in_item_t item;
    item.op    = op;
    item.value = value;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    predict_chars(item);
  endtask

  // Hold the input low until every pending character has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
  endtask

  task automatic test_directed_cases();
    send_number(OP_UDEC, 32'd0);
    send_number(OP_UDEC, 32'd1);
    send_number(OP_UDEC, 32'd9);
    send_number(OP_UDEC, 32'd10);
    send_number(OP_UDEC, 32'd999_999_999);
    send_number(OP_UDEC, 32'd1_000_000_000);
    send_number(OP_UDEC, 32'hFFFF_FFFF);
    send_number(OP_SDEC, 32'd0);
    send_number(OP_SDEC, 32'd7);
    send_number(OP_SDEC, 32'hFFFF_FFFF);
    send_number(OP_SDEC, 32'h7FFF_FFFF);
    send_number(OP_SDEC, 32'h8000_0000);
    send_number(OP_SDEC, 32'h8000_0001);
    send_number(OP_SDEC, 32'hC465_3600);
    send_number(OP_HEX, 32'h0000_0000);
    send_number(OP_HEX, 32'hFFFF_FFFF);
    send_number(OP_HEX, 32'h0123_4567);
    send_number(OP_HEX, 32'h89AB_CDEF);
    send_number(OP_HEX, 32'hA5A5_5A5A);
    send_number(OP_HEX_ALIAS, 32'h0000_0000);
    send_number(OP_HEX_ALIAS, 32'hFEDC_BA98);
    send_number(OP_HEX_ALIAS, 32'h8000_0000);
  endtask

  task automatic test_random_numbers(input int count);
    repeat (count) send_number(2'($urandom_range(3)), pick_value());
  endtask

  // Run a stretch with no idling on either side
  task automatic test_back_to_back(input int count);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_numbers(count);
    tx_idle_pct = 19;
    rx_idle_pct = 19;
  endtask

  // Let the block drain completely, then resume
  task automatic test_drain_and_resume(input int count);
    test_random_numbers(count / 2);
    wait_drained();
    send_number(OP_SDEC, 32'h8000_0000);
    test_random_numbers(count - count / 2 - 1);
  endtask

  // Stall the output side at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // Compare each accepted character against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected character, expected none, actual 0x%h last %b",
                 $time, out_data.char_code, out_data.last);
      end else begin
        want_char = pending_chars.pop_front();
        if (out_data.char_code !== want_char.char_code) begin
          errors++;
          $display("%0t: char_code mismatch, expected 0x%h, actual 0x%h",
                   $time, want_char.char_code, out_data.char_code);
        end
        if (out_data.last !== want_char.last) begin
          errors++;
          $display("%0t: last mismatch, expected %b, actual %b",
                   $time, want_char.last, out_data.last);
        end
      end
    end
  end

  // End the run when neither channel moves a transaction for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_numbers(150);
    test_back_to_back(40);
    test_drain_and_resume(20);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_chars.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== binary_to_ascii_number_formatter_unit.f =====
rtl/b2a_pkg.sv
rtl/b2a_dabble.sv
rtl/b2a_emit.sv
rtl/binary_to_ascii_number_formatter_unit.sv
tb/sv/tb_binary_to_ascii_number_formatter_unit.sv
